// ===== hdl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants for the lottery ticket scheduler.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int OP_W          = 2;
    localparam int ID_W          = 8;
    localparam int TICKET_W      = 16;
    localparam int DRAW_W        = 7;
    localparam int STATUS_W      = 2;
    localparam int TOTAL_W       = 20;
    localparam int PROD_W        = 23;
    localparam int PERCENT_SCALE = 100;
    localparam logic [TICKET_W-1:0] TICKET_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 2'd0,
        OP_NORMALIZE = 2'd1,
        OP_SELECT    = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_WINNER = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM_RD,
        S_NORM_MUL,
        S_NORM_DIV,
        S_NORM_WR,
        S_SEL_RD,
        S_SEL_CHK,
        S_RESULT
    } t_state;

endpackage

// ===== hdl/lts_div.sv =====
// ----------------------------------------------------------------------------
// lts_div
// Restoring divider, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
module lts_div
    import lts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROD_W-1:0]  i_dividend,
    input  logic [TOTAL_W-1:0] i_divisor,
    output logic               o_done,
    output logic [PROD_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [TOTAL_W-1:0] r_rem;
    logic [TOTAL_W-1:0] r_div;
    logic [PROD_W-1:0]  r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    logic [TOTAL_W:0]   w_trial;
    logic [TOTAL_W:0]   w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_quo[PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(PROD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[TOTAL_W-1:0] : w_trial[TOTAL_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/lottery_ticket_scheduler.sv =====
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler
// Process table with ticket counts: add, normalize to percent, select winner.
// ----------------------------------------------------------------------------
// One transaction in gives one result transaction. The input is taken only
// while the block is idle; the result sits in an output register, so the next
// transaction is taken while a result waits. A select scans the entries in
// order, one memory read and one add-compare per entry scanned. A normalize
// works on each entry in turn: a read, a multiply that starts the 23-step
// restoring divider, and a write-back of the saturated quotient.
module lottery_ticket_scheduler
    import lts_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [ID_W-1:0]     i_proc_id,
    input  logic [TICKET_W-1:0] i_ticket_count,
    input  logic [DRAW_W-1:0]   i_draw,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ID_W-1:0]     o_winner_id,
    output logic [STATUS_W-1:0] o_status
);

    localparam int CW    = $clog2(MAX_PROCESSES + 1);
    localparam int IW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int SUM_W = TICKET_W + CW;

    logic [ID_W-1:0]     mem_ids     [MAX_PROCESSES];
    logic [TICKET_W-1:0] mem_tickets [MAX_PROCESSES];

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [CW-1:0]       r_idx, n_idx;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [DRAW_W-1:0]   r_draw, n_draw;
    logic [ID_W-1:0]     r_res_id, n_res_id;
    t_status             r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [ID_W-1:0]     r_rd_id;
    logic [TICKET_W-1:0] r_rd_ticket;

    logic                w_accept;
    logic                w_take;
    logic                w_rd_en;
    logic                w_id_we;
    logic                w_tk_we;
    logic [IW-1:0]       w_waddr;
    logic [TICKET_W-1:0] w_tk_wdata;
    logic                w_div_start;
    logic                w_div_done;
    logic [PROD_W-1:0]   w_quo;
    logic [PROD_W-1:0]   w_prod;
    logic [SUM_W-1:0]    w_sum_next;
    logic [CW-1:0]       w_idx_inc;

    assign w_accept   = i_valid && !o_stall;
    assign w_take     = r_out_valid && !i_stall;
    assign w_sum_next = r_sum + {{(SUM_W-TICKET_W){1'b0}}, r_rd_ticket};
    assign w_idx_inc  = r_idx + CW'(1);
    assign w_prod     = PROD_W'(r_rd_ticket) * PROD_W'(PERCENT_SCALE);

    lts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_total),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_idx        = r_idx;
        n_sum        = r_sum;
        n_draw       = r_draw;
        n_res_id     = r_res_id;
        n_res_status = r_res_status;
        n_out_valid  = w_take ? 1'b0 : r_out_valid;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        w_rd_en      = 1'b0;
        w_id_we      = 1'b0;
        w_tk_we      = 1'b0;
        w_waddr      = r_idx[IW-1:0];
        w_tk_wdata   = i_ticket_count;
        w_div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_id     = '0;
                    n_res_status = ST_OK;
                    n_idx        = '0;
                    n_sum        = '0;
                    n_draw       = i_draw;
                    n_state      = S_RESULT;
                    case (t_op'(i_operation))
                        OP_ADD: begin
                            if (r_count == CW'(MAX_PROCESSES)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_id_we = 1'b1;
                                w_tk_we = 1'b1;
                                w_waddr = r_count[IW-1:0];
                                n_count = r_count + CW'(1);
                                n_total = r_total
                                        + {{(TOTAL_W-TICKET_W){1'b0}}, i_ticket_count};
                            end
                        end
                        OP_NORMALIZE: begin
                            if (r_total != '0 && r_count != '0) begin
                                n_state = S_NORM_RD;
                            end
                        end
                        OP_SELECT: begin
                            if (r_count == '0) begin
                                n_res_status = ST_NO_WINNER;
                            end else begin
                                n_state = S_SEL_RD;
                            end
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_NORM_RD: begin
                w_rd_en = 1'b1;
                n_state = S_NORM_MUL;
            end
            S_NORM_MUL: begin
                w_div_start = 1'b1;
                n_state     = S_NORM_DIV;
            end
            S_NORM_DIV: begin
                if (w_div_done) begin
                    n_state = S_NORM_WR;
                end
            end
            S_NORM_WR: begin
                w_tk_we    = 1'b1;
                w_tk_wdata = (w_quo > PROD_W'(TICKET_MAX)) ? TICKET_MAX
                                                           : w_quo[TICKET_W-1:0];
                n_idx      = w_idx_inc;
                n_state    = (w_idx_inc == r_count) ? S_RESULT : S_NORM_RD;
            end
            S_SEL_RD: begin
                w_rd_en = 1'b1;
                n_state = S_SEL_CHK;
            end
            S_SEL_CHK: begin
                n_sum = w_sum_next;
                n_idx = w_idx_inc;
                if (w_sum_next >= {{(SUM_W-DRAW_W){1'b0}}, r_draw}) begin
                    n_res_id = r_rd_id;
                    n_state  = S_RESULT;
                end else if (w_idx_inc == r_count) begin
                    n_res_status = ST_NO_WINNER;
                    n_state      = S_RESULT;
                end else begin
                    n_state = S_SEL_RD;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || w_take) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_res_id;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_sum        <= n_sum;
        r_draw       <= n_draw;
        r_res_id     <= n_res_id;
        r_res_status <= n_res_status;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_id_we) begin
            mem_ids[w_waddr] <= i_proc_id;
        end
        if (w_tk_we) begin
            mem_tickets[w_waddr] <= w_tk_wdata;
        end
        if (w_rd_en) begin
            r_rd_id     <= mem_ids[r_idx[IW-1:0]];
            r_rd_ticket <= mem_tickets[r_idx[IW-1:0]];
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_winner_id = r_out_id;
    assign o_status    = r_out_status;

endmodule

// ===== tb/tb_lottery_ticket_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lottery_ticket_scheduler
// Self-checking bench for the lottery ticket scheduler. Add, normalize, select
// and unused-code transactions are driven with random gaps and output
// back-pressure. Each accepted transaction is run through a cycle-free model
// of the process table, and the winner id and status that it yields are
// compared with the block's result.
// ----------------------------------------------------------------------------
module tb_lottery_ticket_scheduler
    import lts_pkg::*;
();

    localparam int MAX_PROCESSES = 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1580;
    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 500;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [ID_W-1:0]     winner;
        logic [STATUS_W-1:0] status;
    } t_grant;

    class lottery_tracker;
        logic [ID_W-1:0]     ids [MAX_PROCESSES];
        logic [TICKET_W-1:0] tickets [MAX_PROCESSES];
        int                  count;
        logic [TOTAL_W-1:0]  total;
        t_grant              grants_due [$];
        int                  errors;

        function new();
            count  = 0;
            total  = '0;
            errors = 0;
        endfunction

        function void apply_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                    logic [TICKET_W-1:0] tk, logic [DRAW_W-1:0] draw);
            t_grant          g;
            longint unsigned sum;
            longint unsigned q;
            bit              found;
            g.winner = '0;
            g.status = ST_OK;
            case (op)
                OP_ADD: begin
                    if (count >= MAX_PROCESSES) begin
                        g.status = ST_FULL;
                    end else begin
                        ids[count]     = id;
                        tickets[count] = tk;
                        count++;
                        total = total + TOTAL_W'(tk);
                    end
                end
                OP_NORMALIZE: begin
                    if (total != '0) begin
                        for (int k = 0; k < count; k++) begin
                            q = (64'(tickets[k]) * 64'(PERCENT_SCALE)) / 64'(total);
                            tickets[k] = (q > 64'(TICKET_MAX)) ? TICKET_MAX : q[TICKET_W-1:0];
                        end
                    end
                end
                OP_SELECT: begin
                    sum      = 0;
                    found    = 1'b0;
                    g.status = ST_NO_WINNER;
                    for (int k = 0; k < count && !found; k++) begin
                        sum += 64'(tickets[k]);
                        if (sum >= 64'(draw)) begin
                            g.winner = ids[k];
                            g.status = ST_OK;
                            found    = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            grants_due = {grants_due, g};
        endfunction

        function void check_grant(logic [ID_W-1:0] winner, logic [STATUS_W-1:0] status);
            t_grant g;
            if (grants_due.size() == 0) begin
                $error("result with none pending: winner_id %0d status %0d", winner, status);
                errors++;
            end else begin
                g = grants_due.pop_front();
                if (winner !== g.winner) begin
                    $error("winner_id mismatch: expected %0d, actual %0d", g.winner, winner);
                    errors++;
                end
                if (status !== g.status) begin
                    $error("status mismatch: expected %0d, actual %0d", g.status, status);
                    errors++;
                end
            end
        endfunction

        function int pending_grants();
            return grants_due.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OP_W-1:0]     i_operation;
    logic [ID_W-1:0]     i_proc_id;
    logic [TICKET_W-1:0] i_ticket_count;
    logic [DRAW_W-1:0]   i_draw;
    logic                o_valid;
    logic                i_stall;
    logic [ID_W-1:0]     o_winner_id;
    logic [STATUS_W-1:0] o_status;

    lottery_tracker tracker;
    bit             hold_req = 1'b0;
    int             calm_left = 0;
    int             idle_cycles = 0;

    lottery_ticket_scheduler #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_proc_id      (i_proc_id),
        .i_ticket_count (i_ticket_count),
        .i_draw         (i_draw),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_winner_id    (o_winner_id),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int p;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 8) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // small counts first so that draws spread over many entries
    function automatic logic [TICKET_W-1:0] pick_tickets();
        if (tracker.count < 10) return TICKET_W'($urandom_range(0, 12));
        if (tracker.count < 15) return TICKET_W'($urandom_range(100, 5000));
        if (tracker.count == 15) return TICKET_MAX;
        return TICKET_W'($urandom());
    endfunction

    function automatic logic [DRAW_W-1:0] pick_draw();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) return '0;
        if (p < 15) return DRAW_W'($urandom_range(0, 127));
        return DRAW_W'($urandom_range(1, 100));
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                             logic [TICKET_W-1:0] tk, logic [DRAW_W-1:0] draw);
        int gap;
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_proc_id      <= id;
        i_ticket_count <= tk;
        i_draw         <= draw;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        tracker.apply_request(op, id, tk, draw);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_grants();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pending_grants() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_item(OP_SELECT,    8'd0,   16'd0,     7'd50);
        send_item(OP_NORMALIZE, 8'd0,   16'd0,     7'd0);
        send_item(OP_UNUSED,    8'hFF,  16'hFFFF,  7'h7F);
        send_item(OP_ADD,       8'd0,   16'd0,     7'd0);
        send_item(OP_NORMALIZE, 8'hFF,  16'hFFFF,  7'h7F);
        send_item(OP_SELECT,    8'd0,   16'd0,     7'd0);
        send_item(OP_SELECT,    8'd0,   16'd0,     7'd1);
        send_item(OP_ADD,       8'hFF,  16'd1,     7'd0);
        send_item(OP_SELECT,    8'd0,   16'd0,     7'd1);
        send_item(OP_SELECT,    8'd0,   16'd0,     7'h7F);
        send_item(OP_SELECT,    8'd0,   16'd0,     7'd100);
        send_item(OP_ADD,       8'hA5,  16'd99,    7'd0);
        send_item(OP_SELECT,    8'd0,   16'd0,     7'd100);
        send_item(OP_SELECT,    8'd0,   16'd0,     7'd2);
    endtask

    task automatic run_random();
        logic [OP_W-1:0] op;
        int              pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (n == 400) begin
                hold_req  = 1'b1;
                calm_left = 40;
            end
            if (n == 800) wait_for_grants();
            if (tracker.count < MAX_PROCESSES) begin
                op = (pick < 45) ? OP_ADD : (pick < 95) ? OP_SELECT : OP_UNUSED;
            end else if (n % 200 == 199) begin
                op = OP_NORMALIZE;
            end else begin
                op = (pick < 75) ? OP_SELECT : (pick < 95) ? OP_ADD : OP_UNUSED;
            end
            send_item(op, ID_W'($urandom_range(0, 255)), pick_tickets(), pick_draw());
        end
    endtask

    // receiver back-pressure
    initial begin
        int span;
        int mode;
        i_stall = 1'b0;
        forever begin
            span = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            repeat (span) begin
                @(negedge i_clk);
                if (hold_req) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    i_stall <= 1'b0;
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 99) < 30);
                        2: i_stall <= ($urandom_range(0, 99) < 75);
                        default: begin
                            if ($urandom_range(0, 49) == 0) begin
                                i_stall <= 1'b1;
                                repeat ($urandom_range(20, 80)) @(negedge i_clk);
                            end
                            i_stall <= 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            tracker.check_grant(o_winner_id, o_status);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        tracker        = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_ADD;
        i_proc_id      = '0;
        i_ticket_count = '0;
        i_draw         = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        wait_for_grants();
        run_random();
        wait_for_grants();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_grants() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
